@@ src/fmc_pkg.sv @@
`default_nettype none

package fmc_pkg;

    // Widths fixed by the item and register formats.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int MG_W        = 14;
    localparam int TICKS_W     = 32;

    // Item kinds.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_MOTION  = 2'd2;

    // Modes.
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_TEST     = 2'd1;
    localparam logic [1:0] MODE_ARMED    = 2'd2;
    localparam logic [1:0] MODE_RECOVERY = 2'd3;

    // Events reported with each result.
    localparam logic [1:0] EV_NONE          = 2'd0;
    localparam logic [1:0] EV_AUTO_ARM      = 2'd1;
    localparam logic [1:0] EV_AUTO_RECOVERY = 2'd2;
    localparam logic [1:0] EV_COMMANDED     = 2'd3;

    // Command request codes; codes seven to fourteen are device tests.
    localparam logic [3:0] REQ_DISARM         = 4'd0;
    localparam logic [3:0] REQ_ARM            = 4'd1;
    localparam logic [3:0] REQ_ENTER_TEST     = 4'd2;
    localparam logic [3:0] REQ_ENTER_RECOV    = 4'd3;
    localparam logic [3:0] REQ_QUERY          = 4'd4;
    localparam logic [3:0] REQ_RESET_STATS    = 4'd5;
    localparam logic [3:0] REQ_TEST           = 4'd6;
    localparam logic [3:0] REQ_DEV_TEST_FIRST = 4'd7;
    localparam logic [3:0] REQ_DEV_TEST_LAST  = 4'd14;
    localparam logic [3:0] REQ_OTHER          = 4'd15;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_ARM      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_RECOVERY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_THRESH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_HOLD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_G         = 3'd4;

    // Configuration reset values.
    localparam logic [TICKS_W-1:0] RST_AUTO_ARM      = 32'd300000;
    localparam logic [TICKS_W-1:0] RST_AUTO_RECOVERY = 32'd60000;
    localparam logic [MG_W-1:0]    RST_MOTION_THRESH = 14'd200;
    localparam logic [TICKS_W-1:0] RST_MOTION_HOLD   = 32'd10000;
    localparam logic [MG_W-1:0]    RST_ONE_G         = 14'd1000;

    typedef struct packed {
        logic [TICKS_W-1:0] auto_arm_ticks;
        logic [TICKS_W-1:0] auto_recovery_ticks;
        logic [MG_W-1:0]    motion_threshold_mg;
        logic [TICKS_W-1:0] motion_hold_ticks;
        logic [MG_W-1:0]    one_g_mg;
    } fmc_cfg_t;

    typedef struct packed {
        logic [1:0]      command;
        logic [3:0]      request_code;
        logic [MG_W-1:0] accel_mg;
    } fmc_item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       accepted;
        logic [1:0] event_res;
        logic       moving;
    } fmc_result_t;

endpackage

`default_nettype wire

@@ src/flight_mode_controller.sv @@
// Flight mode controller: tracks one of four modes (idle, test, armed,
// recovery) and reports the mode after every item it consumes.
//
// Input channel (s_valid/s_ready): each request is a millisecond tick, a
// command request or an acceleration report, selected by s_command.
// Result channel (m_valid/m_ready): exactly one result per request, in order,
// carrying the mode, the command verdict, any mode-change event and the
// current motion flag.
// Requests pass through an input register, then a single short compare and
// update step writes the result register whenever that register is empty or
// being drained. Throughput is one request per cycle as long as m_ready stays
// high. When the receiver stalls, the result register holds and the input
// register fills; s_ready then drops until the result is taken, so nothing is
// lost. The user must write the configuration registers through
// cfg_wr_en/cfg_index/cfg_wdata only while no request is in flight; the block
// does not enforce this. Reset (synchronous, aresetn low) returns the block to
// idle with all elapsed counters and the motion flag cleared, empties both
// registers and restores the default timeouts and thresholds.
`default_nettype none

module flight_mode_controller
    import fmc_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_command,
    input  wire logic [3:0]             s_request_code,
    input  wire logic [MG_W-1:0]        s_accel_mg,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_mode,
    output logic                        m_accepted,
    output logic [1:0]                  m_event_res,
    output logic                        m_moving
);

    fmc_cfg_t    cfg;
    fmc_item_t   item_reg;
    logic        in_valid_reg;
    fmc_result_t core_result;
    fmc_result_t res_reg;
    logic        out_valid_reg;
    logic        advance;

    // The held request moves into the result register whenever that register
    // is empty or being drained in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fmc_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .item      (item_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    // Input register: valid is control, the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command      <= s_command;
            item_reg.request_code <= s_request_code;
            item_reg.accel_mg     <= s_accel_mg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_mode      = res_reg.mode;
    assign m_accepted  = res_reg.accepted;
    assign m_event_res = res_reg.event_res;
    assign m_moving    = res_reg.moving;

`ifndef ASSERT_OFF
    // A stalled result is never overwritten by the next request.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result register overwritten while stalled");

    // Automatic arming always lands in armed with the verdict set.
    a_auto_arm_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_AUTO_ARM |-> m_mode == MODE_ARMED && m_accepted)
        else $error("automatic arm reported outside armed");

    // Automatic recovery only happens while no motion is flagged.
    a_auto_recov_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_AUTO_RECOVERY |-> m_mode == MODE_RECOVERY && !m_moving)
        else $error("automatic recovery reported with wrong mode or motion");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

@@ src/fmc_cfg_regs.sv @@
`default_nettype none

module fmc_cfg_regs
    import fmc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output fmc_cfg_t                    cfg
);

    fmc_cfg_t cfg_reg;
    fmc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_AUTO_ARM:      cfg_next.auto_arm_ticks      = cfg_wdata;
                CFG_AUTO_RECOVERY: cfg_next.auto_recovery_ticks = cfg_wdata;
                CFG_MOTION_THRESH: cfg_next.motion_threshold_mg = cfg_wdata[MG_W-1:0];
                CFG_MOTION_HOLD:   cfg_next.motion_hold_ticks   = cfg_wdata;
                CFG_ONE_G:         cfg_next.one_g_mg            = cfg_wdata[MG_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_arm_ticks      <= RST_AUTO_ARM;
            cfg_reg.auto_recovery_ticks <= RST_AUTO_RECOVERY;
            cfg_reg.motion_threshold_mg <= RST_MOTION_THRESH;
            cfg_reg.motion_hold_ticks   <= RST_MOTION_HOLD;
            cfg_reg.one_g_mg            <= RST_ONE_G;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/fmc_core.sv @@
`default_nettype none

module fmc_core
    import fmc_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_fire,
    input  fmc_item_t      item,
    input  fmc_cfg_t       cfg,
    output fmc_result_t    result
);

    localparam int CMP_W = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;

    logic [1:0]              mode_reg,  mode_next;
    logic [COUNTER_BITS-1:0] idle_reg,  idle_next;
    logic [COUNTER_BITS-1:0] armed_reg, armed_next;
    logic [COUNTER_BITS-1:0] still_reg, still_next;
    logic                    flag_reg,  flag_next;

    logic [COUNTER_BITS-1:0] idle_inc, armed_inc, still_inc;
    logic [MG_W-1:0]         dev;
    logic                    accepted;
    logic [1:0]              event_res;

    assign idle_inc  = (&idle_reg)  ? idle_reg  : idle_reg  + 1'b1;
    assign armed_inc = (&armed_reg) ? armed_reg : armed_reg + 1'b1;
    assign still_inc = (&still_reg) ? still_reg : still_reg + 1'b1;
    assign dev = (item.accel_mg >= cfg.one_g_mg) ? item.accel_mg - cfg.one_g_mg
                                                 : cfg.one_g_mg - item.accel_mg;

    always_comb begin
        mode_next  = mode_reg;
        idle_next  = idle_reg;
        armed_next = armed_reg;
        still_next = still_reg;
        flag_next  = flag_reg;
        accepted   = 1'b1;
        event_res  = EV_NONE;
        case (item.command)
            KIND_TICK: begin
                idle_next  = idle_inc;
                armed_next = armed_inc;
                still_next = still_inc;
                if (mode_reg == MODE_IDLE &&
                    CMP_W'(idle_inc) >= CMP_W'(cfg.auto_arm_ticks)) begin
                    mode_next  = MODE_ARMED;
                    armed_next = '0;
                    still_next = '0;
                    flag_next  = 1'b0;
                    event_res  = EV_AUTO_ARM;
                end else if (mode_reg == MODE_ARMED && !flag_reg &&
                             CMP_W'(armed_inc) > CMP_W'(cfg.auto_recovery_ticks) &&
                             CMP_W'(still_inc) > CMP_W'(cfg.auto_recovery_ticks)) begin
                    mode_next = MODE_RECOVERY;
                    event_res = EV_AUTO_RECOVERY;
                end
            end
            KIND_COMMAND: begin
                case (item.request_code)
                    REQ_DISARM: begin
                        if (mode_reg != MODE_IDLE) begin
                            mode_next = MODE_IDLE;
                            idle_next = '0;
                            event_res = EV_COMMANDED;
                        end
                    end
                    REQ_ARM: begin
                        if (mode_reg == MODE_IDLE || mode_reg == MODE_TEST) begin
                            mode_next  = MODE_ARMED;
                            armed_next = '0;
                            still_next = '0;
                            flag_next  = 1'b0;
                            event_res  = EV_COMMANDED;
                        end else begin
                            accepted = (mode_reg == MODE_ARMED);
                        end
                    end
                    REQ_ENTER_TEST: begin
                        if (mode_reg == MODE_IDLE) begin
                            mode_next = MODE_TEST;
                            event_res = EV_COMMANDED;
                        end else begin
                            accepted = (mode_reg == MODE_TEST);
                        end
                    end
                    REQ_ENTER_RECOV: begin
                        if (mode_reg == MODE_ARMED) begin
                            mode_next = MODE_RECOVERY;
                            event_res = EV_COMMANDED;
                        end else begin
                            accepted = (mode_reg == MODE_RECOVERY);
                        end
                    end
                    REQ_QUERY, REQ_RESET_STATS: accepted = 1'b1;
                    REQ_TEST:  accepted = (mode_reg == MODE_IDLE || mode_reg == MODE_TEST);
                    REQ_OTHER: accepted = (mode_reg == MODE_IDLE || mode_reg == MODE_ARMED);
                    default:   accepted = (mode_reg == MODE_TEST);
                endcase
            end
            KIND_MOTION: begin
                if (dev > cfg.motion_threshold_mg) begin
                    still_next = '0;
                    flag_next  = 1'b1;
                end else if (CMP_W'(still_reg) > CMP_W'(cfg.motion_hold_ticks)) begin
                    flag_next = 1'b0;
                end
            end
            default: accepted = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            idle_reg  <= '0;
            armed_reg <= '0;
            still_reg <= '0;
            flag_reg  <= 1'b0;
        end else if (item_fire) begin
            mode_reg  <= mode_next;
            idle_reg  <= idle_next;
            armed_reg <= armed_next;
            still_reg <= still_next;
            flag_reg  <= flag_next;
        end
    end

    assign result.mode      = mode_next;
    assign result.accepted  = accepted;
    assign result.event_res = event_res;
    assign result.moving    = flag_next;

`ifndef ASSERT_OFF
    // An item other than a command never reports a commanded change.
    a_cmd_event_only: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item.command != KIND_COMMAND |-> event_res != EV_COMMANDED)
        else $error("commanded event from a non-command item");

    // Armed entry always starts with motion cleared.
    a_arm_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && mode_reg != MODE_ARMED && mode_next == MODE_ARMED |=>
        !flag_reg && still_reg == '0 && armed_reg == '0)
        else $error("armed entered without clearing motion state");

    // State only moves when an item is consumed.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_fire |=> $stable(mode_reg) && $stable(flag_reg) && $stable(still_reg))
        else $error("controller state changed without an item");
`endif

endmodule

`default_nettype wire

@@ verif/flight_mode_controller_test.sv @@
`timescale 1ns / 1ps

module flight_mode_controller_test;
    import fmc_pkg::*;

    // The controller is built with its default counter width; the mode tracker
    // below keeps its elapsed counters at the same width.
    localparam int COUNT_W = 32;

    // Item kind three is not decoded by the block: it must be refused with no
    // state change.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int ACCEL_MAX        = 2 ** MG_W - 1;
    localparam int PAD_W            = CFG_DATA_W - MG_W;
    localparam int RESET_CYCLES     = 2;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 100;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int CYCLE_LIMIT      = 200000;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_EVERY_THIRD
    } ready_style_e;

    // Mode tracker: keeps its own copy of the controller state and settings,
    // works out the result of every accepted request and checks the results
    // that come back, in order.
    class mode_tracker;
        logic [TICKS_W-1:0] arm_timeout;
        logic [TICKS_W-1:0] recovery_timeout;
        logic [MG_W-1:0]    threshold;
        logic [TICKS_W-1:0] hold_time;
        logic [MG_W-1:0]    one_g;

        logic [1:0]         mode;
        logic [COUNT_W-1:0] idle_ms;
        logic [COUNT_W-1:0] armed_ms;
        logic [COUNT_W-1:0] still_ms;
        logic               moving;

        fmc_result_t expected_outcomes[$];
        int errors;
        int checked;
        int requests;
        int refused;
        int event_count[4];

        function new();
            arm_timeout      = RST_AUTO_ARM;
            recovery_timeout = RST_AUTO_RECOVERY;
            threshold        = RST_MOTION_THRESH;
            hold_time        = RST_MOTION_HOLD;
            one_g            = RST_ONE_G;
            mode             = MODE_IDLE;
            idle_ms          = '0;
            armed_ms         = '0;
            still_ms         = '0;
            moving           = 1'b0;
            errors           = 0;
            checked          = 0;
            requests         = 0;
            refused          = 0;
            event_count      = '{0, 0, 0, 0};
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AUTO_ARM:      arm_timeout = data;
                CFG_AUTO_RECOVERY: recovery_timeout = data;
                CFG_MOTION_THRESH: threshold = data[MG_W-1:0];
                CFG_MOTION_HOLD:   hold_time = data;
                CFG_ONE_G:         one_g = data[MG_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] count);
            return (&count) ? count : count + 1'b1;
        endfunction

        function void enter_mode(logic [1:0] target);
            if (target == MODE_IDLE) begin
                idle_ms = '0;
            end else if (target == MODE_ARMED) begin
                armed_ms = '0;
                still_ms = '0;
                moving   = 1'b0;
            end
            mode = target;
        endfunction

        // Applies the permission table and the legal mode changes.
        function logic judge_command(logic [3:0] code, output logic [1:0] ev);
            ev = EV_NONE;
            case (code)
                REQ_DISARM: begin
                    if (mode != MODE_IDLE) begin
                        enter_mode(MODE_IDLE);
                        ev = EV_COMMANDED;
                    end
                    return 1'b1;
                end
                REQ_ARM: begin
                    if (mode == MODE_IDLE || mode == MODE_TEST) begin
                        enter_mode(MODE_ARMED);
                        ev = EV_COMMANDED;
                        return 1'b1;
                    end
                    return mode == MODE_ARMED;
                end
                REQ_ENTER_TEST: begin
                    if (mode == MODE_IDLE) begin
                        enter_mode(MODE_TEST);
                        ev = EV_COMMANDED;
                        return 1'b1;
                    end
                    return mode == MODE_TEST;
                end
                REQ_ENTER_RECOV: begin
                    if (mode == MODE_ARMED) begin
                        enter_mode(MODE_RECOVERY);
                        ev = EV_COMMANDED;
                        return 1'b1;
                    end
                    return mode == MODE_RECOVERY;
                end
                REQ_QUERY, REQ_RESET_STATS: return 1'b1;
                REQ_TEST:  return mode == MODE_IDLE || mode == MODE_TEST;
                REQ_OTHER: return mode == MODE_IDLE || mode == MODE_ARMED;
                default:   return mode == MODE_TEST;
            endcase
        endfunction

        function fmc_result_t predict_outcome(fmc_item_t req);
            fmc_result_t     outcome;
            logic [MG_W-1:0] deviation;
            logic [1:0]      ev;
            outcome.accepted  = 1'b1;
            outcome.event_res = EV_NONE;
            case (req.command)
                KIND_TICK: begin
                    idle_ms  = bump(idle_ms);
                    armed_ms = bump(armed_ms);
                    still_ms = bump(still_ms);
                    if (mode == MODE_IDLE && idle_ms >= arm_timeout) begin
                        enter_mode(MODE_ARMED);
                        outcome.event_res = EV_AUTO_ARM;
                    end else if (mode == MODE_ARMED && !moving &&
                                 armed_ms > recovery_timeout &&
                                 still_ms > recovery_timeout) begin
                        enter_mode(MODE_RECOVERY);
                        outcome.event_res = EV_AUTO_RECOVERY;
                    end
                end
                KIND_COMMAND: begin
                    outcome.accepted  = judge_command(req.request_code, ev);
                    outcome.event_res = ev;
                end
                KIND_MOTION: begin
                    deviation = (req.accel_mg >= one_g) ? req.accel_mg - one_g
                                                        : one_g - req.accel_mg;
                    if (deviation > threshold) begin
                        still_ms = '0;
                        moving   = 1'b1;
                    end else if (still_ms > hold_time) begin
                        moving = 1'b0;
                    end
                end
                default: outcome.accepted = 1'b0;
            endcase
            outcome.mode   = mode;
            outcome.moving = moving;
            return outcome;
        endfunction

        function void note_request(fmc_item_t req);
            fmc_result_t outcome;
            outcome = predict_outcome(req);
            requests++;
            event_count[outcome.event_res]++;
            if (req.command == KIND_COMMAND && !outcome.accepted) refused++;
            expected_outcomes.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(fmc_result_t seen);
            fmc_result_t want;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result (mode %0d accepted %0d event %0d moving %0d)",
                         $time, seen.mode, seen.accepted, seen.event_res, seen.moving);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            checked++;
            compare_field("mode", want.mode, seen.mode);
            compare_field("accepted", {1'b0, want.accepted}, {1'b0, seen.accepted});
            compare_field("event_res", want.event_res, seen.event_res);
            compare_field("moving", {1'b0, want.moving}, {1'b0, seen.moving});
        endfunction
    endclass

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_command      = KIND_TICK;
    logic [3:0]             s_request_code = REQ_DISARM;
    logic [MG_W-1:0]        s_accel_mg     = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [1:0]             m_mode;
    logic                   m_accepted;
    logic [1:0]             m_event_res;
    logic                   m_moving;

    mode_tracker tracker = new();

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_off_pending = 1'b0;
    int          settings_loaded  = 0;
    int unsigned cycle_count      = 0;

    flight_mode_controller #(
        .COUNTER_BITS(COUNT_W)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_request_code (s_request_code),
        .s_accel_mg     (s_accel_mg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode         (m_mode),
        .m_accepted     (m_accepted),
        .m_event_res    (m_event_res),
        .m_moving       (m_moving)
    );

    always #1 aclk = ~aclk;

    // Both channels are sampled right at the rising edge, before any of the
    // nonblocking updates of that edge land, so the values seen here are the
    // ones the block itself saw. A request is noted before a result is
    // checked, although no request can ever meet its own result on one edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_request('{s_command, s_request_code, s_accel_mg});
            end
            if (m_valid && m_ready) begin
                tracker.check_outcome('{m_mode, m_accepted, m_event_res, m_moving});
            end
        end
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver. It switches between stretches of steady readiness,
    // random stalls and a fixed one-in-three pattern, with an occasional short
    // hold-off. When the stimulus asks for it, it holds off for a long stretch
    // so that the block fills up and has to drop s_ready.
    initial begin : result_receiver
        ready_style_e style;
        int           span_left;
        int           hold_left;
        style     = READY_ALWAYS;
        span_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = LONG_HOLD_CYCLES;
            end else if (hold_left == 0 && span_left <= 0) begin
                style     = ready_style_e'($urandom_range(0, 2));
                span_left = $urandom_range(8, 120);
                if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(10, 40);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                span_left--;
                case (style)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:      m_ready <= (span_left % 3 == 0);
                endcase
            end
        end
    end

    // Offers one request and returns on the edge at which it is accepted.
    // The payload stays put until then; the next call may replace it at once.
    task automatic send_item(input logic [1:0] kind, input logic [3:0] code,
                             input logic [MG_W-1:0] accel);
        s_valid        <= 1'b1;
        s_command      <= kind;
        s_request_code <= code;
        s_accel_mg     <= accel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic issue_request(input logic [3:0] code);
        send_item(KIND_COMMAND, code, MG_W'($urandom));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(KIND_TICK, 4'($urandom), MG_W'($urandom));
    endtask

    task automatic report_accel(input logic [MG_W-1:0] accel);
        send_item(KIND_MOTION, 4'($urandom), accel);
    endtask

    // Stops offering requests and waits until every result is back, then a
    // few more cycles so the pipeline is surely empty.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.set_register(idx, data);
    endtask

    // Writes all five registers. The narrow milli-g registers get random
    // upper bits, which the block must ignore.
    task automatic load_settings(input logic [TICKS_W-1:0] arm_ms,
                                 input logic [TICKS_W-1:0] recovery_ms,
                                 input logic [MG_W-1:0] thresh,
                                 input logic [TICKS_W-1:0] hold_ms,
                                 input logic [MG_W-1:0] gravity);
        write_register(CFG_AUTO_ARM, arm_ms);
        write_register(CFG_AUTO_RECOVERY, recovery_ms);
        write_register(CFG_MOTION_THRESH, {PAD_W'($urandom), thresh});
        write_register(CFG_MOTION_HOLD, hold_ms);
        write_register(CFG_ONE_G, {PAD_W'($urandom), gravity});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_loaded++;
    endtask

    // Random requests in bursts of random length with random gaps. Most are
    // ticks, so the timeouts actually expire; commands lean toward the mode
    // changes, and most acceleration reports sit near the motion threshold.
    task automatic send_random_items(input int count);
        int              sent;
        int              burst;
        int              gap;
        int              roll;
        int              center;
        int              spread;
        int              offset;
        int              value;
        logic [1:0]      kind;
        logic [3:0]      code;
        logic [MG_W-1:0] accel;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < count; b++) begin
                roll  = $urandom_range(0, 99);
                code  = 4'($urandom);
                accel = MG_W'($urandom);
                if (roll < 60) begin
                    kind = KIND_TICK;
                end else if (roll < 74) begin
                    kind = KIND_COMMAND;
                    if ($urandom_range(0, 2) != 0) begin
                        case ($urandom_range(0, 5))
                            0, 1:    code = REQ_ARM;
                            2:       code = REQ_ENTER_RECOV;
                            3:       code = REQ_ENTER_TEST;
                            4:       code = REQ_DISARM;
                            default: code = REQ_QUERY;
                        endcase
                    end
                end else if (roll < 97) begin
                    kind   = KIND_MOTION;
                    center = int'(tracker.one_g);
                    spread = int'(tracker.threshold);
                    case ($urandom_range(0, 9))
                        0, 1: value = int'($urandom_range(0, ACCEL_MAX));
                        2: begin
                            // Right at the threshold or one milli-g past it.
                            offset = spread + int'($urandom_range(0, 1));
                            value  = $urandom_range(0, 1) ? center + offset : center - offset;
                        end
                        3, 4: begin
                            offset = spread + 1 + int'($urandom_range(0, 300));
                            value  = $urandom_range(0, 1) ? center + offset : center - offset;
                        end
                        default: value = center - spread + int'($urandom_range(0, 2 * spread));
                    endcase
                    if (value < 0) value = 0;
                    else if (value > ACCEL_MAX) value = ACCEL_MAX;
                    accel = MG_W'(value);
                end else begin
                    kind = KIND_UNUSED;
                end
                send_item(kind, code, accel);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with short timeouts so that both automatic
        // transitions show up within a handful of ticks.
        load_settings(32'd3, 32'd4, 14'd200, 32'd5, 14'd1000);

        // Permission table in idle, then the walk through test, armed and
        // recovery, including requests for the mode already held.
        issue_request(REQ_DISARM);
        issue_request(REQ_QUERY);
        issue_request(REQ_RESET_STATS);
        issue_request(REQ_TEST);
        issue_request(REQ_DEV_TEST_FIRST);
        issue_request(REQ_OTHER);
        issue_request(REQ_ENTER_RECOV);
        issue_request(REQ_ENTER_TEST);
        issue_request(REQ_ENTER_TEST);
        issue_request(REQ_DEV_TEST_LAST);
        issue_request(REQ_OTHER);
        issue_request(REQ_ARM);
        issue_request(REQ_ARM);
        issue_request(REQ_TEST);
        issue_request(REQ_ENTER_RECOV);
        issue_request(REQ_ENTER_RECOV);
        issue_request(REQ_OTHER);
        issue_request(REQ_DISARM);

        // Motion reports act in idle too; an undecoded kind changes nothing.
        report_accel(14'h3FFF);
        report_accel(14'd0);
        send_item(KIND_UNUSED, 4'($urandom), MG_W'($urandom));

        // The third tick in idle arms the block and clears the motion flag.
        // A deviation of exactly the threshold is not motion, one more is.
        send_ticks(3);
        report_accel(14'd1200);
        report_accel(14'd799);

        // While moving, recovery must wait. Once the still time passes the
        // hold time, a quiet report clears the flag and the next tick
        // moves the block into recovery on its own.
        send_ticks(6);
        report_accel(14'd1000);
        send_ticks(1);
        wait_for_quiet();

        // Random phases, each under its own settings: a moderate set, all
        // zeros, all ones, a tight set, a random set and the reset values.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_settings(32'd20, 32'd30, 14'd200, 32'd10, 14'd1000);
                1: load_settings('0, '0, '0, '0, '0);
                2: load_settings('1, '1, '1, '1, '1);
                3: load_settings(32'd8, 32'd3, 14'd50, 32'd2, 14'd16000);
                4: load_settings($urandom_range(0, 60), $urandom_range(0, 40),
                                 MG_W'($urandom_range(0, 400)), $urandom_range(0, 30),
                                 MG_W'($urandom_range(0, ACCEL_MAX)));
                default: load_settings(RST_AUTO_ARM, RST_AUTO_RECOVERY, RST_MOTION_THRESH,
                                       RST_MOTION_HOLD, RST_ONE_G);
            endcase
            if (p == 0) hold_off_pending = 1'b1;
            send_random_items(ITEMS_PER_PHASE);
            wait_for_quiet();
        end

        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
            tracker.errors++;
        end
        $display("Checked %0d results for %0d requests under %0d register settings.",
                 tracker.checked, tracker.requests, settings_loaded);
        $display("Saw %0d automatic arms, %0d automatic recoveries,",
                 tracker.event_count[EV_AUTO_ARM], tracker.event_count[EV_AUTO_RECOVERY]);
        $display("%0d commanded changes and %0d refusals.",
                 tracker.event_count[EV_COMMANDED], tracker.refused);
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
